[hw/rtl/srgb_xyz_converter_assert.svh]
// Assertion macros shared by the converter's checker.
`ifndef SRGB_XYZ_CONVERTER_ASSERT_SVH
`define SRGB_XYZ_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SXC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SXC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sxc_pkg.sv]
// Shared widths, coefficient sources and gamma tables of the sRGB/XYZ converter.
`default_nettype none

package sxc_pkg;

  localparam int RGB_W       = 8;
  localparam int XYZ_W       = 14;
  localparam int Q24_W       = 25;
  localparam int Q24_FRAC    = 24;
  localparam int NUM_CH      = 3;
  localparam int NUM_COEF    = 9;
  localparam int FWD_DEPTH   = 5;
  localparam int INV_DEPTH   = 5;
  localparam int GAMMA_DEPTH = RGB_W;
  localparam int TAB_SIZE    = 256;

  localparam int unsigned XYZ_MAX   = 16383;
  localparam int unsigned XYZ_SCALE = 10000;

  localparam longint Q24_ONE  = longint'(1) <<< Q24_FRAC;
  localparam longint Q24_HALF = longint'(1) <<< (Q24_FRAC - 1);

  typedef logic [Q24_W-1:0] q24_t;
  typedef q24_t q24_tab_t [TAB_SIZE];
  typedef longint micro_tab_t [NUM_COEF];

  // Matrix entries in millionths, row major.
  localparam micro_tab_t FWD_MICRO = '{
    412453, 357580, 180423,
    212671, 715160, 72169,
    19334, 119193, 950227
  };
  localparam micro_tab_t INV_MICRO = '{
    3240600, -1537200, -498600,
    -968900, 1875800, 41500,
    55700, -204000, 1057000
  };

  // Rounds a matrix entry to frac fraction bits, halves away from zero.
  function automatic longint quant_coef(input longint micro, input int frac);
    longint mag;
    longint q;
    mag = (micro < 0) ? -micro : micro;
    q = ((mag <<< frac) + 500000) / 1000000;
    return (micro < 0) ? -q : q;
  endfunction

  function automatic longint pow5_q24(input longint r);
    longint p;
    int k;
    p = r;
    for (k = 0; k < 4; k++) begin
      p = (p * r) >>> Q24_FRAC;
    end
    return p;
  endfunction

  // Power branch of the decode: t^2.4 as (t^2) * fifth_root(t^2).
  function automatic longint pow_tail(input longint t);
    longint s;
    longint lo;
    longint hi;
    longint mid;
    s = (t * t + Q24_HALF) >>> Q24_FRAC;
    lo = 0;
    hi = Q24_ONE;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 1) >>> 1);
      if (pow5_q24(mid) <= s) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return (s * lo + Q24_HALF) >>> Q24_FRAC;
  endfunction

  // Linear light of code c, that is the decode of c/255.
  function automatic q24_tab_t build_lin();
    q24_tab_t tab;
    longint   n;
    longint   v;
    int       c;
    tab[0] = '0;
    for (c = 1; c < TAB_SIZE; c++) begin
      n = longint'(c);
      if (100000 * n < 4045 * 255) begin
        v = (100 * n * Q24_ONE + 164730) / 329460;
      end else begin
        v = pow_tail(((1000 * n + 14025) * Q24_ONE + 134512) / 269025);
      end
      tab[c] = q24_t'(v);
    end
    return tab;
  endfunction

  // Decision thresholds: the decode of (2c-1)/510, the midpoint below code c.
  function automatic q24_tab_t build_thr();
    q24_tab_t tab;
    longint   n;
    longint   v;
    int       c;
    tab[0] = '0;
    for (c = 1; c < TAB_SIZE; c++) begin
      n = 2 * longint'(c) - 1;
      if (100000 * n < 4045 * 510) begin
        v = (100 * n * Q24_ONE + 329460) / 658920;
      end else begin
        v = pow_tail(((1000 * n + 28050) * Q24_ONE + 269025) / 538050);
      end
      tab[c] = q24_t'(v);
    end
    return tab;
  endfunction

  localparam q24_tab_t LIN_TAB = build_lin();
  localparam q24_tab_t THR_TAB = build_thr();

endpackage

`default_nettype wire

[hw/rtl/sxc_fwd.sv]
// RGB to XYZ pipeline: table linearization, 3x3 matrix, scaling to ten-thousandths.
`default_nettype none

module sxc_fwd import sxc_pkg::*; #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic [FWD_DEPTH-1:0] en_i,
  input  logic [RGB_W-1:0]     red_i,
  input  logic [RGB_W-1:0]     green_i,
  input  logic [RGB_W-1:0]     blue_i,
  output logic [XYZ_W-1:0]     x_o,
  output logic [XYZ_W-1:0]     y_o,
  output logic [XYZ_W-1:0]     z_o
);

  localparam int CW = COEF_FRAC_BITS;
  localparam int PW = Q24_W + CW;
  localparam int AW = PW + 2;
  localparam int BW = AW + XYZ_W;
  localparam int SH = Q24_FRAC + COEF_FRAC_BITS;
  localparam int RW = BW + 1 - SH;

  logic [CW-1:0]    coef   [NUM_COEF];
  logic [RGB_W-1:0] rgb    [NUM_CH];
  logic [Q24_W-1:0] lin_q  [NUM_CH];
  logic [PW-1:0]    prod_q [NUM_COEF];
  logic [AW-1:0]    acc_q  [NUM_CH];
  logic [BW-1:0]    big_q  [NUM_CH];
  logic [RW-1:0]    rnd    [NUM_CH];
  logic [XYZ_W-1:0] xyz_q  [NUM_CH];

  for (genvar j = 0; j < NUM_COEF; j++) begin : g_coef
    localparam longint CVAL = quant_coef(FWD_MICRO[j], COEF_FRAC_BITS);
    assign coef[j] = CW'(CVAL);
  end

  assign rgb[0] = red_i;
  assign rgb[1] = green_i;
  assign rgb[2] = blue_i;

  always_comb begin
    for (int r = 0; r < NUM_CH; r++) begin
      rnd[r] = RW'(((BW+1)'(big_q[r]) + ((BW+1)'(1) << (SH - 1))) >> SH);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < NUM_CH; r++) begin
      if (en_i[0]) begin
        lin_q[r] <= LIN_TAB[rgb[r]];
      end
      for (int k = 0; k < NUM_CH; k++) begin
        if (en_i[1]) begin
          prod_q[NUM_CH*r+k] <= PW'(coef[NUM_CH*r+k]) * PW'(lin_q[k]);
        end
      end
      if (en_i[2]) begin
        acc_q[r] <= AW'(prod_q[NUM_CH*r]) + AW'(prod_q[NUM_CH*r+1])
                  + AW'(prod_q[NUM_CH*r+2]);
      end
      if (en_i[3]) begin
        big_q[r] <= BW'(acc_q[r]) * BW'(XYZ_SCALE);
      end
      if (en_i[4]) begin
        xyz_q[r] <= (rnd[r] > RW'(XYZ_MAX)) ? XYZ_W'(XYZ_MAX) : XYZ_W'(rnd[r]);
      end
    end
  end

  assign x_o = xyz_q[0];
  assign y_o = xyz_q[1];
  assign z_o = xyz_q[2];

endmodule

`default_nettype wire

[hw/rtl/sxc_inv.sv]
// XYZ to linear RGB pipeline: inverse matrix, rounding division, clip detection.
`default_nettype none

module sxc_inv import sxc_pkg::*; #(
  parameter int COEF_FRAC_BITS    = 16,
  parameter int LINEAR_INDEX_BITS = 12
) (
  input  logic                         clk_i,
  input  logic [INV_DEPTH-1:0]         en_i,
  input  logic [XYZ_W-1:0]             x_i,
  input  logic [XYZ_W-1:0]             y_i,
  input  logic [XYZ_W-1:0]             z_i,
  output logic [LINEAR_INDEX_BITS:0]   q_o [NUM_CH],
  output logic [NUM_CH-1:0]            zero_o,
  output logic                         clip_o
);

  localparam int L   = LINEAR_INDEX_BITS;
  localparam int CW  = COEF_FRAC_BITS + 3;
  localparam int PW  = CW + XYZ_W + 1;
  localparam int SW  = PW + 2;
  localparam int MW  = SW + L;
  localparam int UW  = L + 14;
  localparam int QW  = L + 1;
  localparam int RCW = L + 1;
  // floor(m / 10000) is taken as (m * RECIP) >> UW, then corrected by one.
  localparam longint RECIP  = (longint'(1) <<< UW) / XYZ_SCALE;
  localparam longint MU_TOP = longint'(XYZ_SCALE) <<< L;
  localparam longint LIM_HI = MU_TOP + longint'(XYZ_SCALE);
  localparam longint HALF_D = longint'(XYZ_SCALE) / 2;

  logic signed [CW-1:0]   coef  [NUM_COEF];
  logic        [XYZ_W-1:0] xyz  [NUM_CH];
  logic signed [PW-1:0]   p_q   [NUM_COEF];
  logic signed [SW-1:0]   s_q   [NUM_CH];
  logic signed [MW-1:0]   m     [NUM_CH];
  logic        [UW-1:0]   mu_q  [NUM_CH];
  logic        [UW-1:0]   mu2_q [NUM_CH];
  logic        [QW-1:0]   q0_q  [NUM_CH];
  logic        [UW-1:0]   rem   [NUM_CH];
  logic        [QW-1:0]   q_q   [NUM_CH];
  logic [NUM_CH-1:0]      zero2_q, zero3_q, zero4_q;
  logic [NUM_CH-1:0]      under, over;
  logic                   clip2_q, clip3_q, clip4_q;

  for (genvar j = 0; j < NUM_COEF; j++) begin : g_coef
    localparam longint CVAL = quant_coef(INV_MICRO[j], COEF_FRAC_BITS);
    assign coef[j] = CW'(CVAL);
  end

  assign xyz[0] = x_i;
  assign xyz[1] = y_i;
  assign xyz[2] = z_i;

  always_comb begin
    for (int r = 0; r < NUM_CH; r++) begin
      // floor(s * 2^L / 2^F) plus half the divisor's integer part.
      m[r]     = ((MW'(s_q[r]) <<< L) >>> COEF_FRAC_BITS) + MW'(HALF_D);
      under[r] = m[r] < 0;
      over[r]  = m[r] >= MW'(LIM_HI);
      rem[r]   = mu2_q[r] - UW'(UW'(q0_q[r]) * UW'(XYZ_SCALE));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < NUM_CH; r++) begin
      for (int k = 0; k < NUM_CH; k++) begin
        if (en_i[0]) begin
          p_q[NUM_CH*r+k] <= PW'(coef[NUM_CH*r+k]) * PW'(signed'({1'b0, xyz[k]}));
        end
      end
      if (en_i[1]) begin
        s_q[r] <= SW'(p_q[NUM_CH*r]) + SW'(p_q[NUM_CH*r+1]) + SW'(p_q[NUM_CH*r+2]);
      end
      if (en_i[2]) begin
        if (over[r]) begin
          mu_q[r] <= UW'(MU_TOP);
        end else if (under[r]) begin
          mu_q[r] <= '0;
        end else begin
          mu_q[r] <= UW'(m[r]);
        end
      end
      if (en_i[3]) begin
        q0_q[r]  <= QW'((UW'(0) + (UW+RCW)'(mu_q[r]) * (UW+RCW)'(RECIP)) >> UW);
        mu2_q[r] <= mu_q[r];
      end
      if (en_i[4]) begin
        q_q[r] <= q0_q[r] + QW'(rem[r] >= UW'(XYZ_SCALE));
      end
    end
    if (en_i[2]) begin
      zero2_q <= under;
      clip2_q <= |(under | over);
    end
    if (en_i[3]) begin
      zero3_q <= zero2_q;
      clip3_q <= clip2_q;
    end
    if (en_i[4]) begin
      zero4_q <= zero3_q;
      clip4_q <= clip3_q;
    end
  end

  assign q_o    = q_q;
  assign zero_o = zero4_q;
  assign clip_o = clip4_q;

endmodule

`default_nettype wire

[hw/rtl/sxc_gamma.sv]
// Gamma encode: a pipelined binary search of the code thresholds, one code bit per stage.
`default_nettype none

module sxc_gamma import sxc_pkg::*; #(
  parameter int LINEAR_INDEX_BITS = 12
) (
  input  logic                       clk_i,
  input  logic [GAMMA_DEPTH-1:0]     en_i,
  input  logic [LINEAR_INDEX_BITS:0] q_i [NUM_CH],
  input  logic [NUM_CH-1:0]          zero_i,
  output logic [RGB_W-1:0]           code_o [NUM_CH]
);

  localparam int LSH = Q24_FRAC - LINEAR_INDEX_BITS;

  logic [Q24_W-1:0]  lvl_q  [GAMMA_DEPTH][NUM_CH];
  logic [RGB_W-1:0]  code_q [GAMMA_DEPTH][NUM_CH];
  logic [NUM_CH-1:0] zero_q [GAMMA_DEPTH];

  for (genvar st = 0; st < GAMMA_DEPTH; st++) begin : g_stage
    localparam int BIT = GAMMA_DEPTH - 1 - st;

    logic [Q24_W-1:0]  lvl_in  [NUM_CH];
    logic [RGB_W-1:0]  code_in [NUM_CH];
    logic [RGB_W-1:0]  cand    [NUM_CH];
    logic [NUM_CH-1:0] zero_in;

    if (st == 0) begin : g_first
      for (genvar r = 0; r < NUM_CH; r++) begin : g_ch
        assign lvl_in[r]  = Q24_W'(q_i[r]) << LSH;
        assign code_in[r] = '0;
      end
      assign zero_in = zero_i;
    end else begin : g_next
      assign lvl_in  = lvl_q[st-1];
      assign code_in = code_q[st-1];
      assign zero_in = zero_q[st-1];
    end

    always_comb begin
      for (int r = 0; r < NUM_CH; r++) begin
        cand[r] = code_in[r] | (RGB_W'(1) << BIT);
      end
    end

    // Keep the bit when the threshold of the candidate code is reached.
    always_ff @(posedge clk_i) begin
      if (en_i[st]) begin
        for (int r = 0; r < NUM_CH; r++) begin
          lvl_q[st][r]  <= lvl_in[r];
          code_q[st][r] <= (THR_TAB[cand[r]] <= lvl_in[r]) ? cand[r] : code_in[r];
        end
        zero_q[st] <= zero_in;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_CH; r++) begin
      code_o[r] = zero_q[GAMMA_DEPTH-1][r] ? '0 : code_q[GAMMA_DEPTH-1][r];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/srgb_xyz_converter.sv]
// Top level of the sRGB / CIE XYZ (D65) pixel converter.
//
//   Channel | Handshake               | Beat payload
//   --------+-------------------------+-------------------------------------------
//   in      | in_valid_i / in_ready_o | kind, red/green/blue_in, x/y/z_in
//   out     | out_valid_o/out_ready_i | red/green/blue_out, x/y/z_out, clipped
//
// One beat is accepted per cycle unless a stall at the output backs up to the input;
// a result is offered once its input beat has passed 13 register stages: the 5
// matrix stages plus the 8 stages of the gamma search.
// Every stage has its own valid bit and loads whenever it is empty or its
// successor loads, so bubbles close up and a stalled output holds its beat.
// Reset clears the valid bits only; the gamma tables are constants.
`default_nettype none

module srgb_xyz_converter import sxc_pkg::*; #(
  parameter int COEF_FRAC_BITS    = 16,
  parameter int LINEAR_INDEX_BITS = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             kind_i,
  input  logic [RGB_W-1:0] red_in_i,
  input  logic [RGB_W-1:0] green_in_i,
  input  logic [RGB_W-1:0] blue_in_i,
  input  logic [XYZ_W-1:0] x_in_i,
  input  logic [XYZ_W-1:0] y_in_i,
  input  logic [XYZ_W-1:0] z_in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [RGB_W-1:0] red_out_o,
  output logic [RGB_W-1:0] green_out_o,
  output logic [RGB_W-1:0] blue_out_o,
  output logic [XYZ_W-1:0] x_out_o,
  output logic [XYZ_W-1:0] y_out_o,
  output logic [XYZ_W-1:0] z_out_o,
  output logic             clipped_o
);

  localparam int N = FWD_DEPTH + GAMMA_DEPTH;

  logic [N-1:0]             en;
  logic [N-1:0]             valid_q;
  logic [N-1:0]             kind_q;
  logic [XYZ_W-1:0]         fx, fy, fz;
  logic [XYZ_W-1:0]         xd_q [GAMMA_DEPTH][NUM_CH];
  logic [GAMMA_DEPTH-1:0]   clip_q;
  logic [LINEAR_INDEX_BITS:0] lin_q [NUM_CH];
  logic [NUM_CH-1:0]        zero;
  logic                     clip;
  logic [RGB_W-1:0]         code [NUM_CH];

  assign en[N-1] = !valid_q[N-1] || out_ready_i;
  for (genvar k = 0; k < N - 1; k++) begin : g_en
    assign en[k] = !valid_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  sxc_fwd #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_fwd (
    .clk_i  (clk_i),
    .en_i   (en[FWD_DEPTH-1:0]),
    .red_i  (red_in_i),
    .green_i(green_in_i),
    .blue_i (blue_in_i),
    .x_o    (fx),
    .y_o    (fy),
    .z_o    (fz)
  );

  sxc_inv #(
    .COEF_FRAC_BITS   (COEF_FRAC_BITS),
    .LINEAR_INDEX_BITS(LINEAR_INDEX_BITS)
  ) u_inv (
    .clk_i (clk_i),
    .en_i  (en[INV_DEPTH-1:0]),
    .x_i   (x_in_i),
    .y_i   (y_in_i),
    .z_i   (z_in_i),
    .q_o   (lin_q),
    .zero_o(zero),
    .clip_o(clip)
  );

  sxc_gamma #(
    .LINEAR_INDEX_BITS(LINEAR_INDEX_BITS)
  ) u_gamma (
    .clk_i (clk_i),
    .en_i  (en[N-1:FWD_DEPTH]),
    .q_i   (lin_q),
    .zero_i(zero),
    .code_o(code)
  );

  // Kind, clip flag and the forward result ride alongside the gamma search.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      kind_q[0] <= kind_i;
    end
    for (int k = 1; k < N; k++) begin
      if (en[k]) begin
        kind_q[k] <= kind_q[k-1];
      end
    end
    if (en[FWD_DEPTH]) begin
      xd_q[0][0] <= fx;
      xd_q[0][1] <= fy;
      xd_q[0][2] <= fz;
      clip_q[0]  <= clip;
    end
    for (int k = 1; k < GAMMA_DEPTH; k++) begin
      if (en[FWD_DEPTH+k]) begin
        xd_q[k]   <= xd_q[k-1];
        clip_q[k] <= clip_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[N-1];

  assign red_out_o   = kind_q[N-1] ? code[0] : '0;
  assign green_out_o = kind_q[N-1] ? code[1] : '0;
  assign blue_out_o  = kind_q[N-1] ? code[2] : '0;
  assign clipped_o   = kind_q[N-1] && clip_q[GAMMA_DEPTH-1];
  assign x_out_o     = kind_q[N-1] ? '0 : xd_q[GAMMA_DEPTH-1][0];
  assign y_out_o     = kind_q[N-1] ? '0 : xd_q[GAMMA_DEPTH-1][1];
  assign z_out_o     = kind_q[N-1] ? '0 : xd_q[GAMMA_DEPTH-1][2];

endmodule

`default_nettype wire

[hw/rtl/sxc_checker.sv]
// Port-level checker for the converter, bound to the top level.
`default_nettype none

`include "srgb_xyz_converter_assert.svh"

module sxc_checker import sxc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [RGB_W-1:0] red_out_o,
  input logic [RGB_W-1:0] green_out_o,
  input logic [RGB_W-1:0] blue_out_o,
  input logic [XYZ_W-1:0] x_out_o,
  input logic [XYZ_W-1:0] y_out_o,
  input logic [XYZ_W-1:0] z_out_o,
  input logic             clipped_o
);

  logic xyz_zero;
  logic rgb_any;

  assign xyz_zero = (x_out_o == '0) && (y_out_o == '0) && (z_out_o == '0);
  assign rgb_any  = (red_out_o != '0) || (green_out_o != '0) || (blue_out_o != '0);

  // A beat waiting at the output keeps its payload.
  `SXC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(red_out_o) && $stable(x_out_o) && $stable(clipped_o),
    "output beat changed while stalled")

  // With an empty output register the whole pipeline can move.
  `SXC_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o,
    "input not ready while output is empty")

  // An RGB result never carries XYZ values.
  `SXC_ASSERT_NOW(a_rgb_excl, clk_i, rst_ni, out_valid_o && rgb_any, xyz_zero,
    "rgb and xyz fields both nonzero")

  // Clipping only exists in the XYZ to RGB direction.
  `SXC_ASSERT_NOW(a_clip_excl, clk_i, rst_ni, out_valid_o && clipped_o, xyz_zero,
    "clipped set on an xyz result")

endmodule

bind srgb_xyz_converter sxc_checker u_sxc_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
// Testbench for the sRGB / CIE XYZ pixel converter with an in-line predictor.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import sxc_pkg::*;

  localparam int COEF_FRAC  = 16;
  localparam int LIN_BITS   = 12;
  localparam int GAMMA_SIZE = (1 << LIN_BITS) + 1;
  localparam int TIMEOUT    = 200000;
  localparam int DRAIN      = 40;

  typedef enum logic {KIND_RGB2XYZ = 1'b0, KIND_XYZ2RGB = 1'b1} kind_e;

  typedef struct packed {
    logic [RGB_W-1:0] red;
    logic [RGB_W-1:0] green;
    logic [RGB_W-1:0] blue;
    logic [XYZ_W-1:0] x;
    logic [XYZ_W-1:0] y;
    logic [XYZ_W-1:0] z;
    logic             clipped;
  } pixel_t;

  class conv_scoreboard;
    longint fwd_coef[9];
    longint inv_coef[9];
    longint lin_light[256];
    byte unsigned gamma_code[GAMMA_SIZE];
    pixel_t pending_pix[$];
    int errors;

    function longint round_coef(longint micro);
      longint mag;
      longint q;
      mag = (micro < 0) ? -micro : micro;
      q = ((mag <<< COEF_FRAC) + 500000) / 1000000;
      return (micro < 0) ? -q : q;
    endfunction

    function longint fifth_power(longint r);
      longint p;
      p = r;
      for (int k = 0; k < 4; k++) p = (p * r) >>> 24;
      return p;
    endfunction

    // sRGB decode of num/den into Q24 linear light.
    function longint srgb_decode(longint num, longint den);
      longint d;
      longint t;
      longint s;
      longint lo;
      longint hi;
      longint mid;
      if (100000 * num < 4045 * den) begin
        d = 1292 * den;
        return (100 * num * (longint'(1) << 24) + d / 2) / d;
      end
      d = 1055 * den;
      t = ((1000 * num + 55 * den) * (longint'(1) << 24) + d / 2) / d;
      s = (t * t + (longint'(1) << 23)) >>> 24;
      lo = 0;
      hi = longint'(1) << 24;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (fifth_power(mid) <= s) lo = mid;
        else hi = mid - 1;
      end
      return (s * lo + (longint'(1) << 23)) >>> 24;
    endfunction

    function new();
      longint fwd_m[9] = '{412453, 357580, 180423, 212671, 715160, 72169,
                           19334, 119193, 950227};
      longint inv_m[9] = '{3240600, -1537200, -498600, -968900, 1875800, 41500,
                           55700, -204000, 1057000};
      longint thr[256];
      longint level;
      int c;
      for (int i = 0; i < 9; i++) begin
        fwd_coef[i] = round_coef(fwd_m[i]);
        inv_coef[i] = round_coef(inv_m[i]);
      end
      lin_light[0] = 0;
      thr[0] = 0;
      for (int k = 1; k < 256; k++) begin
        lin_light[k] = srgb_decode(k, 255);
        thr[k] = srgb_decode(2 * k - 1, 510);
      end
      c = 0;
      for (int i = 0; i < GAMMA_SIZE; i++) begin
        level = longint'(i) << (24 - LIN_BITS);
        while (c < 255 && thr[c + 1] <= level) c++;
        gamma_code[i] = byte'(c);
      end
      errors = 0;
    endfunction

    function logic [XYZ_W-1:0] to_xyz(int row, longint lin[3]);
      longint unsigned acc;
      longint unsigned v;
      acc = 0;
      for (int k = 0; k < 3; k++)
        acc += longint'(fwd_coef[3 * row + k]) * longint'(lin[k]);
      v = (acc * 10000 + (64'd1 << (23 + COEF_FRAC))) >> (24 + COEF_FRAC);
      return (v > 16383) ? 14'd16383 : v[XYZ_W-1:0];
    endfunction

    function logic [RGB_W-1:0] to_rgb(int row, longint xyz[3], ref logic clip);
      longint s;
      longint n;
      longint q;
      longint d;
      s = 0;
      d = longint'(10000) << COEF_FRAC;
      for (int k = 0; k < 3; k++) s += inv_coef[3 * row + k] * xyz[k];
      n = s * (longint'(1) << LIN_BITS) + d / 2;
      q = (n >= 0) ? n / d : -((-n + d - 1) / d);
      if (q < 0) begin
        clip = 1'b1;
        return '0;
      end
      if (q > (longint'(1) << LIN_BITS)) begin
        clip = 1'b1;
        return 8'd255;
      end
      return gamma_code[q];
    endfunction

    function void note_pixel(kind_e kind, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [13:0] x, logic [13:0] y, logic [13:0] z);
      pixel_t p;
      longint lin[3];
      longint xyz[3];
      logic clip;
      p = '0;
      if (kind == KIND_RGB2XYZ) begin
        lin[0] = lin_light[r];
        lin[1] = lin_light[g];
        lin[2] = lin_light[b];
        p.x = to_xyz(0, lin);
        p.y = to_xyz(1, lin);
        p.z = to_xyz(2, lin);
      end else begin
        xyz[0] = x;
        xyz[1] = y;
        xyz[2] = z;
        clip = 1'b0;
        p.red = to_rgb(0, xyz, clip);
        p.green = to_rgb(1, xyz, clip);
        p.blue = to_rgb(2, xyz, clip);
        p.clipped = clip;
      end
      pending_pix.push_back(p);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pix.size() == 0) begin
        report_mismatch("result beat with no pixel outstanding");
        return;
      end
      want = pending_pix.pop_front();
      if (got.red != want.red) report_mismatch($sformatf("red %0d exp %0d", got.red, want.red));
      if (got.green != want.green)
        report_mismatch($sformatf("green %0d exp %0d", got.green, want.green));
      if (got.blue != want.blue)
        report_mismatch($sformatf("blue %0d exp %0d", got.blue, want.blue));
      if (got.x != want.x) report_mismatch($sformatf("x %0d exp %0d", got.x, want.x));
      if (got.y != want.y) report_mismatch($sformatf("y %0d exp %0d", got.y, want.y));
      if (got.z != want.z) report_mismatch($sformatf("z %0d exp %0d", got.z, want.z));
      if (got.clipped != want.clipped)
        report_mismatch($sformatf("clipped %0b exp %0b", got.clipped, want.clipped));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             kind_i = 1'b0;
  logic [RGB_W-1:0] red_in_i = '0;
  logic [RGB_W-1:0] green_in_i = '0;
  logic [RGB_W-1:0] blue_in_i = '0;
  logic [XYZ_W-1:0] x_in_i = '0;
  logic [XYZ_W-1:0] y_in_i = '0;
  logic [XYZ_W-1:0] z_in_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [RGB_W-1:0] red_out_o;
  logic [RGB_W-1:0] green_out_o;
  logic [RGB_W-1:0] blue_out_o;
  logic [XYZ_W-1:0] x_out_o;
  logic [XYZ_W-1:0] y_out_o;
  logic [XYZ_W-1:0] z_out_o;
  logic             clipped_o;

  conv_scoreboard sb = new();
  logic quiet = 1'b0;
  int   cycle_count = 0;

  always #1 clk_i = ~clk_i;

  srgb_xyz_converter DUT (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT) begin
      $display("srgb_xyz_converter verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) out_ready_i <= quiet || ($urandom_range(99) >= 23);

  // Outputs are sampled mid-cycle, where they hold what the next edge sees.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_pixel({red_out_o, green_out_o, blue_out_o, x_out_o, y_out_o, z_out_o,
                      clipped_o});
  end

  task send_pixel(kind_e kind, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                  logic [13:0] x, logic [13:0] y, logic [13:0] z);
    logic taken;
    // Unless quiet, the input may go idle for a random gap before a pixel is offered.
    if (!quiet && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    red_in_i <= r;
    green_in_i <= g;
    blue_in_i <= b;
    x_in_i <= x;
    y_in_i <= y;
    z_in_i <= z;
    sb.note_pixel(kind, r, g, b, x, y, z);
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task send_random(kind_e kind);
    logic [13:0] x;
    logic [13:0] y;
    logic [13:0] z;
    // Mostly colors near the gamut so the gamma table is exercised.
    if ($urandom_range(99) < 70) begin
      x = 14'($urandom_range(9600));
      y = 14'($urandom_range(10100));
      z = 14'($urandom_range(11000));
    end else begin
      x = 14'($urandom);
      y = 14'($urandom);
      z = 14'($urandom);
    end
    send_pixel(kind, 8'($urandom), 8'($urandom), 8'($urandom), x, y, z);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel(KIND_RGB2XYZ, 0, 0, 0, 14'h3fff, 14'h3fff, 14'h3fff);
    send_pixel(KIND_RGB2XYZ, 255, 255, 255, 0, 0, 0);
    send_pixel(KIND_RGB2XYZ, 255, 0, 0, 0, 0, 0);
    send_pixel(KIND_RGB2XYZ, 0, 255, 0, 0, 0, 0);
    send_pixel(KIND_RGB2XYZ, 0, 0, 255, 0, 0, 0);
    send_pixel(KIND_RGB2XYZ, 1, 10, 11, 0, 0, 0);
    send_pixel(KIND_RGB2XYZ, 128, 170, 85, 0, 0, 0);
    send_pixel(KIND_XYZ2RGB, 8'hff, 8'hff, 8'hff, 0, 0, 0);
    send_pixel(KIND_XYZ2RGB, 0, 0, 0, 9505, 10000, 10888);
    send_pixel(KIND_XYZ2RGB, 0, 0, 0, 16383, 16383, 16383);
    send_pixel(KIND_XYZ2RGB, 0, 0, 0, 16383, 0, 0);
    send_pixel(KIND_XYZ2RGB, 0, 0, 0, 0, 16383, 0);
    send_pixel(KIND_XYZ2RGB, 0, 0, 0, 0, 0, 16383);
    send_pixel(KIND_XYZ2RGB, 0, 0, 0, 0, 1000, 0);
    send_pixel(KIND_XYZ2RGB, 0, 0, 0, 4124, 2126, 193);
    send_pixel(KIND_XYZ2RGB, 0, 0, 0, 20, 21, 23);
    send_pixel(KIND_XYZ2RGB, 0, 0, 0, 1, 1, 1);

    for (int i = 0; i < 850; i++) begin
      quiet <= (i >= 300 && i < 420);
      send_random(kind_e'($urandom_range(1)));
    end
    in_valid_i <= 1'b0;
    quiet <= 1'b0;

    while (sb.pending_pix.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (sb.pending_pix.size() != 0) sb.report_mismatch("pixels left without a result");
    if (sb.errors == 0) begin
      $display("srgb_xyz_converter verification clean");
    end else begin
      $display("srgb_xyz_converter verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
